### rtl/nalsp_pkg.sv
// Shared types and constants of the NAL unit splitter.
package nalsp_pkg;

  localparam int CNT_W       = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  localparam logic REG_MAX_TEMPORAL = 1'b0;
  localparam logic REG_LAYER_LIMIT  = 1'b1;

  localparam logic [7:0] START_BYTE = 8'h01;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HDR0,
    PH_HDR1,
    PH_PAY
  } phase_t;

  typedef enum logic [1:0] {
    OP_PAYLOAD,
    OP_RECORD,
    OP_HEADER
  } op_t;

  // One queued job: nzero zeros, then a payload byte, a record or the header.
  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] nzero;
    logic [7:0]       data;
    logic             ovf;
    logic [31:0]      size;
    logic [5:0]       nal_type;
    logic [5:0]       layer;
    logic [2:0]       temporal;
    logic [7:0]       zeros;
  } entry_t;

  typedef struct packed {
    logic [2:0] max_temporal;
    logic [2:0] layer_limit;
  } cfg_t;

endpackage

### rtl/nalsp_in_if.sv
// Input channel: stream bytes and end-of-stream commands.
interface nalsp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_byte;

  modport source (output valid, output cmd, output in_byte, input ready);
  modport sink (input valid, input cmd, input in_byte, output ready);
endinterface

### rtl/nalsp_out_if.sv
// Output channel: routed bytes and finished NAL records.
interface nalsp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic        keep;
  logic [5:0]  layer;
  logic [2:0]  temporal_plus1;
  logic [5:0]  nal_type;
  logic [7:0]  prefix_zeros;
  logic [31:0] nal_size;
  logic        zero_overflow;
  logic        last;

  modport source (output valid, output kind, output out_byte, output keep, output layer,
                  output temporal_plus1, output nal_type, output prefix_zeros,
                  output nal_size, output zero_overflow, output last, input ready);
  modport sink (input valid, input kind, input out_byte, input keep, input layer,
                input temporal_plus1, input nal_type, input prefix_zeros,
                input nal_size, input zero_overflow, input last, output ready);
endinterface

### rtl/nalsp_fifo.sv
// Short job queue between the parser front and the emitter back.
module nalsp_fifo
  import nalsp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  entry_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full       = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("job pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("job popped from an empty queue");

endmodule

### rtl/nalsp_front.sv
// Parser front: start-code search, header capture, zero holding, job issue.
module nalsp_front
  import nalsp_pkg::*;
#(
  parameter int FLUSH_LIMIT = 63,
  parameter int SIZE_BITS   = 32
) (
  input  logic       clk,
  input  logic       rst,
  nalsp_in_if.sink   in_ch,
  input  logic       full,
  output logic       push,
  output entry_t     job
);

  phase_t               phase, phase_next;
  logic [7:0]           zero_run, zero_run_next;
  logic [7:0]           first_hdr, first_hdr_next;
  logic [5:0]           cur_type, cur_type_next;
  logic [5:0]           cur_layer, cur_layer_next;
  logic [2:0]           cur_temporal, cur_temporal_next;
  logic [7:0]           cur_zeros, cur_zeros_next;
  logic [SIZE_BITS-1:0] payload_count, payload_count_next;
  logic                 take;

  function automatic logic [SIZE_BITS-1:0] sat_add(input logic [SIZE_BITS-1:0] a,
                                                   input logic [CNT_W:0] k);
    logic [SIZE_BITS:0] s;
    s = {1'b0, a} + (SIZE_BITS+1)'(k);
    return s[SIZE_BITS] ? '1 : s[SIZE_BITS-1:0];
  endfunction

  assign in_ch.ready = !full;
  assign take        = in_ch.valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      zero_run      <= '0;
      first_hdr     <= '0;
      cur_type      <= '0;
      cur_layer     <= '0;
      cur_temporal  <= '0;
      cur_zeros     <= '0;
      payload_count <= '0;
    end else begin
      phase         <= phase_next;
      zero_run      <= zero_run_next;
      first_hdr     <= first_hdr_next;
      cur_type      <= cur_type_next;
      cur_layer     <= cur_layer_next;
      cur_temporal  <= cur_temporal_next;
      cur_zeros     <= cur_zeros_next;
      payload_count <= payload_count_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    zero_run_next      = zero_run;
    first_hdr_next     = first_hdr;
    cur_type_next      = cur_type;
    cur_layer_next     = cur_layer;
    cur_temporal_next  = cur_temporal;
    cur_zeros_next     = cur_zeros;
    payload_count_next = payload_count;
    push               = 1'b0;
    // jobs carry the NAL context as it stands when the job is issued
    job.op             = OP_PAYLOAD;
    job.nzero          = '0;
    job.data           = '0;
    job.ovf            = 1'b0;
    job.size           = '0;
    job.nal_type       = cur_type;
    job.layer          = cur_layer;
    job.temporal       = cur_temporal;
    job.zeros          = cur_zeros;

    if (take) begin
      if (in_ch.cmd == CMD_EOS) begin
        if (phase == PH_PAY) begin
          push      = 1'b1;
          job.op    = OP_RECORD;
          job.nzero = zero_run[CNT_W-1:0];
          job.size  = 32'(sat_add(payload_count, (CNT_W+1)'(zero_run)));
        end
        phase_next    = PH_HUNT;
        zero_run_next = '0;
      end else begin
        unique case (phase)
          PH_HUNT: begin
            if (in_ch.in_byte == START_BYTE && zero_run > 8'd1) begin
              cur_zeros_next = zero_run;
              zero_run_next  = '0;
              phase_next     = PH_HDR0;
            end else if (in_ch.in_byte == 8'h00) begin
              if (zero_run != 8'hff) begin
                zero_run_next = zero_run + 8'd1;
              end
            end else begin
              zero_run_next = '0;
            end
          end
          PH_HDR0: begin
            first_hdr_next = in_ch.in_byte;
            phase_next     = PH_HDR1;
          end
          PH_HDR1: begin
            cur_type_next      = first_hdr[6:1];
            cur_layer_next     = {first_hdr[0], in_ch.in_byte[7:3]};
            cur_temporal_next  = in_ch.in_byte[2:0];
            push               = 1'b1;
            job.op             = OP_HEADER;
            job.nzero          = (cur_zeros > 8'd3) ? CNT_W'(3) : cur_zeros[CNT_W-1:0];
            job.nal_type       = first_hdr[6:1];
            job.layer          = {first_hdr[0], in_ch.in_byte[7:3]};
            job.temporal       = in_ch.in_byte[2:0];
            payload_count_next = '0;
            zero_run_next      = '0;
            phase_next         = PH_PAY;
          end
          PH_PAY: begin
            if (in_ch.in_byte == 8'h00) begin
              if (zero_run >= 8'(FLUSH_LIMIT)) begin
                // held run is full: force the oldest zero out
                push               = 1'b1;
                job.ovf            = 1'b1;
                payload_count_next = sat_add(payload_count, (CNT_W+1)'(1));
              end else begin
                zero_run_next = zero_run + 8'd1;
              end
            end else if (in_ch.in_byte == START_BYTE && zero_run > 8'd1) begin
              push           = 1'b1;
              job.op         = OP_RECORD;
              job.size       = 32'(payload_count);
              cur_zeros_next = zero_run;
              zero_run_next  = '0;
              phase_next     = PH_HDR0;
            end else begin
              push               = 1'b1;
              job.nzero          = zero_run[CNT_W-1:0];
              job.data           = in_ch.in_byte;
              payload_count_next = sat_add(payload_count, (CNT_W+1)'(zero_run) + 1'b1);
              zero_run_next      = '0;
            end
          end
          default: phase_next = PH_HUNT;
        endcase
      end
    end
  end

  a_run_bounded: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAY |-> zero_run <= 8'(FLUSH_LIMIT))
    else $error("held zero run above flush limit");

endmodule

### rtl/nalsp_back.sv
// Emitter back: expands queued jobs into result transactions.
module nalsp_back
  import nalsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       head_valid,
  input  entry_t     head,
  output logic       pop,
  nalsp_out_if.source out_ch
);

  logic             out_valid;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W:0]   last_idx;
  logic [CNT_W-1:0] off;
  logic             advance;
  logic             last_res;
  logic             in_zero;
  logic             rec;
  logic [7:0]       byte_val;
  logic             keep_val;

  assign last_idx = {1'b0, head.nzero} + ((head.op == OP_HEADER) ? (CNT_W+1)'(2) : '0);
  assign last_res = ({1'b0, cnt} == last_idx);
  assign in_zero  = (cnt < head.nzero);
  assign off      = cnt - head.nzero;
  assign rec      = (head.op == OP_RECORD) && !in_zero;
  assign advance  = head_valid && (!out_valid || out_ch.ready);
  assign pop      = advance && last_res;

  assign keep_val = ({3'b000, cfg.layer_limit} > head.layer) && (head.temporal != 3'd0) &&
                    (head.temporal <= cfg.max_temporal);

  always_comb begin
    byte_val = 8'h00;
    if (!in_zero) begin
      case (head.op)
        OP_PAYLOAD: byte_val = head.data;
        OP_HEADER: begin
          case (off[1:0])
            2'd0:    byte_val = START_BYTE;
            2'd1:    byte_val = {1'b0, head.nal_type, head.layer[5]};
            default: byte_val = {head.layer[4:0], head.temporal};
          endcase
        end
        default: byte_val = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      cnt       <= last_res ? '0 : cnt + 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.kind           <= rec ? KIND_RECORD : KIND_BYTE;
      out_ch.out_byte       <= byte_val;
      out_ch.keep           <= keep_val;
      out_ch.layer          <= head.layer;
      out_ch.temporal_plus1 <= head.temporal;
      out_ch.nal_type       <= head.nal_type;
      out_ch.prefix_zeros   <= head.zeros;
      out_ch.nal_size       <= rec ? head.size : '0;
      out_ch.zero_overflow  <= !in_zero && head.op == OP_PAYLOAD && head.ovf;
      out_ch.last           <= last_res;
    end
  end

  assign out_ch.valid = out_valid;

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> {1'b0, cnt} <= last_idx)
    else $error("result index past end of job");
  a_job_held: assert property (@(posedge clk) disable iff (rst)
    cnt != '0 |-> head_valid)
    else $error("job vanished mid-expansion");

endmodule

### rtl/hevc_nal_unit_splitter_core.sv
// Top level of the Annex B NAL unit splitter: config registers and part wiring.
//
// Usage: in_ch takes one transaction per stream byte (cmd = 0) or an end of
// stream (cmd = 1). out_ch gives tagged transactions: start-code, header and
// payload bytes (kind = 0) and one record per finished NAL (kind = 1); the
// final transaction caused by an input carries last = 1.
// A front part parses the stream and issues one job per input that causes
// results into a four-entry queue; a back part expands each job, one result
// per cycle while out_ch is not stalled, into a registered output stage.
// Throughput: one input per cycle while each input causes at most one result
// and out_ch is not stalled. An input that causes several results holds the
// back until all are out (a header causes up to six, a flushed zero run up to
// FLUSH_LIMIT + 1); the queue absorbs these bursts and in_ch.ready drops only
// when it fills. Each job is registered in the queue and its first result then
// in the output stage. Reset clears parser state, queue and output stage,
// and sets max_temporal to 6 and layer_limit to 7. A stalled out_ch holds its
// transaction and backs up into the queue, then into in_ch. Write the registers
// only while the block is idle.
module hevc_nal_unit_splitter_core
  import nalsp_pkg::*;
#(
  parameter int FLUSH_LIMIT = 63,
  parameter int SIZE_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  nalsp_in_if.sink    in_ch,
  nalsp_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t   cfg;
  logic   cfg_wr;
  logic   push;
  logic   full;
  logic   pop;
  logic   head_valid;
  entry_t job;
  entry_t head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_temporal <= 3'd6;
      cfg.layer_limit  <= 3'd7;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MAX_TEMPORAL: cfg.max_temporal <= pwdata[2:0];
        REG_LAYER_LIMIT:  cfg.layer_limit  <= pwdata[2:0];
        default:          cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_TEMPORAL: prdata = {29'd0, cfg.max_temporal};
      REG_LAYER_LIMIT:  prdata = {29'd0, cfg.layer_limit};
      default:          prdata = '0;
    endcase
  end

  nalsp_front #(
    .FLUSH_LIMIT(FLUSH_LIMIT),
    .SIZE_BITS  (SIZE_BITS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .in_ch(in_ch),
    .full (full),
    .push (push),
    .job  (job)
  );

  nalsp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  nalsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

### bench/hevc_nal_unit_splitter_core_tb.sv
`timescale 1ns / 100ps
// Testbench for the NAL unit splitter: directed and random Annex B streams checked by a parser model.
module hevc_nal_unit_splitter_core_tb;
  import nalsp_pkg::*;

  localparam int FLUSH_LIMIT = 63;
  localparam int SIZE_BITS = 32;
  localparam logic [31:0] SIZE_MAX = 32'((64'd1 << SIZE_BITS) - 1);
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic        keep;
    logic [5:0]  layer;
    logic [2:0]  temporal_plus1;
    logic [5:0]  nal_type;
    logic [7:0]  prefix_zeros;
    logic [31:0] nal_size;
    logic        zero_overflow;
    logic        last;
  } nal_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  nalsp_in_if  in_ch();
  nalsp_out_if out_ch();

  hevc_nal_unit_splitter_core #(
    .FLUSH_LIMIT(FLUSH_LIMIT),
    .SIZE_BITS  (SIZE_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #1 clk = ~clk;

  // Parser model state
  cfg_t        model_cfg;
  phase_t      model_phase;
  int unsigned held_zeros;
  logic [7:0]  hdr_byte0;
  logic [5:0]  cur_nal_type;
  logic [5:0]  cur_layer;
  logic [2:0]  cur_tid;
  logic [7:0]  cur_prefix;
  logic [31:0] payload_len;
  nal_out_t    nal_out_q[$];

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  logic        gaps_on = 1'b1;
  logic        stalls_on = 1'b1;
  logic        hold_pending = 1'b0;
  int unsigned hold_left = 0;

  function automatic void push_out(logic kind, logic [7:0] data, logic ovf, logic [31:0] size);
    nal_out_t r;
    r.kind           = kind;
    r.out_byte       = data;
    r.keep           = (cur_layer < model_cfg.layer_limit) && (cur_tid >= 1) &&
                       (cur_tid <= model_cfg.max_temporal);
    r.layer          = cur_layer;
    r.temporal_plus1 = cur_tid;
    r.nal_type       = cur_nal_type;
    r.prefix_zeros   = cur_prefix;
    r.nal_size       = size;
    r.zero_overflow  = ovf;
    r.last           = 1'b0;
    nal_out_q.push_back(r);
  endfunction

  function automatic void push_payload(logic [7:0] data, logic ovf);
    if (payload_len != SIZE_MAX) payload_len++;
    push_out(KIND_BYTE, data, ovf, '0);
  endfunction

  function automatic void flush_held_zeros();
    while (held_zeros > 0) begin
      push_payload(8'h00, 1'b0);
      held_zeros--;
    end
  endfunction

  function automatic void parse_stream_item(logic cmd, logic [7:0] data);
    int unsigned first;
    int          i;
    nal_out_t    r;
    first = nal_out_q.size();
    if (cmd == CMD_EOS) begin
      if (model_phase == PH_PAY) begin
        flush_held_zeros();
        push_out(KIND_RECORD, 8'h00, 1'b0, payload_len);
      end
      model_phase = PH_HUNT;
      held_zeros = 0;
    end else begin
      case (model_phase)
        PH_HUNT: begin
          if (data == START_BYTE && held_zeros > 1) begin
            cur_prefix = 8'(held_zeros);
            held_zeros = 0;
            model_phase = PH_HDR0;
          end else if (data == 8'h00) begin
            if (held_zeros < 255) held_zeros++;
          end else begin
            held_zeros = 0;
          end
        end
        PH_HDR0: begin
          hdr_byte0 = data;
          model_phase = PH_HDR1;
        end
        PH_HDR1: begin
          cur_nal_type = hdr_byte0[6:1];
          cur_layer = {hdr_byte0[0], data[7:3]};
          cur_tid = data[2:0];
          for (i = 0; i < 3 && i < cur_prefix; i++) push_out(KIND_BYTE, 8'h00, 1'b0, '0);
          push_out(KIND_BYTE, START_BYTE, 1'b0, '0);
          push_out(KIND_BYTE, {1'b0, cur_nal_type, cur_layer[5]}, 1'b0, '0);
          push_out(KIND_BYTE, {cur_layer[4:0], cur_tid}, 1'b0, '0);
          payload_len = '0;
          held_zeros = 0;
          model_phase = PH_PAY;
        end
        default: begin
          if (data == 8'h00) begin
            // a full held run pushes its oldest zero out as payload
            if (held_zeros >= FLUSH_LIMIT) push_payload(8'h00, 1'b1);
            else held_zeros++;
          end else if (data == START_BYTE && held_zeros > 1) begin
            push_out(KIND_RECORD, 8'h00, 1'b0, payload_len);
            cur_prefix = 8'(held_zeros);
            held_zeros = 0;
            model_phase = PH_HDR0;
          end else begin
            flush_held_zeros();
            push_payload(data, 1'b0);
          end
        end
      endcase
    end
    if (nal_out_q.size() > first) begin
      r = nal_out_q.pop_back();
      r.last = 1'b1;
      nal_out_q.push_back(r);
    end
  endfunction

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(9))
      0, 1, 2: return 8'h00;
      3:       return START_BYTE;
      4:       return 8'h03;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly small layers so the layer limit is hit from both sides
  function automatic logic [15:0] random_header();
    logic [5:0] lay;
    lay = ($urandom_range(3) != 0) ? 6'($urandom_range(8)) : 6'($urandom);
    return {($urandom_range(7) == 0), 6'($urandom), lay, 3'($urandom)};
  endfunction

  task automatic send_item(input logic cmd, input logic [7:0] data);
    if (gaps_on && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.in_byte <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    parse_stream_item(cmd, data);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_nal(input int unsigned prefix, input logic [15:0] header,
                          input int unsigned len);
    repeat (prefix) send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, START_BYTE);
    send_item(CMD_BYTE, header[15:8]);
    send_item(CMD_BYTE, header[7:0]);
    repeat (len) send_item(CMD_BYTE, payload_byte());
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (nal_out_q.size() != 0) @(negedge clk);
    // inputs that cause no result may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [2:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {29'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_MAX_TEMPORAL) model_cfg.max_temporal = value;
    else model_cfg.layer_limit = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_directed();
    logic [8:0] seq[$];
    seq = '{
      // lone zero before 0x01, then forbidden bit set and all-ones header
      {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'h01}, {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'h00},
      {CMD_BYTE, 8'h01}, {CMD_BYTE, 8'hFF}, {CMD_BYTE, 8'hFF}, {CMD_BYTE, 8'h00},
      {CMD_BYTE, 8'h01}, {CMD_BYTE, 8'hAB}, {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'h00},
      {CMD_EOS, 8'hFF},
      // end of stream while hunting and inside the header
      {CMD_EOS, 8'h00},
      {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'h01}, {CMD_EOS, 8'h5A},
      // temporal id plus one of zero, empty payload, start code inside payload
      {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'h01},
      {CMD_BYTE, 8'h02}, {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'h00}, {CMD_BYTE, 8'h00},
      {CMD_BYTE, 8'h01}, {CMD_BYTE, 8'h40}, {CMD_BYTE, 8'h01}, {CMD_BYTE, 8'h7F},
      {CMD_EOS, 8'h00}
    };
    foreach (seq[i]) send_item(seq[i][8], seq[i][7:0]);
    wait_idle();
  endtask

  task automatic test_long_zero_runs();
    // overflow a held run, open the next NAL with the truncated run, then flush a full run
    repeat (3) send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, START_BYTE);
    send_item(CMD_BYTE, 8'h26);
    send_item(CMD_BYTE, 8'h01);
    repeat (FLUSH_LIMIT + 1) send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, START_BYTE);
    send_item(CMD_BYTE, 8'h02);
    send_item(CMD_BYTE, 8'h01);
    repeat (FLUSH_LIMIT) send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'h55);
    send_item(CMD_EOS, 8'h00);
    wait_idle();
  endtask

  task automatic test_config_sweep();
    logic [5:0] sweep[$];
    sweep = '{{3'd0, 3'd0}, {3'd7, 3'd7}, {3'd7, 3'd0}, {3'd0, 3'd7},
              {3'd1, 3'd1}, {3'd3, 3'd5}, {3'd6, 3'd7}};
    foreach (sweep[i]) begin
      wait_idle();
      write_reg(REG_MAX_TEMPORAL, sweep[i][5:3]);
      write_reg(REG_LAYER_LIMIT, sweep[i][2:0]);
      send_nal(2, random_header(), $urandom_range(1));
      send_item(CMD_EOS, 8'($urandom));
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_pending = 1'b1;
    wait (hold_left != 0);
    hold_pending = 1'b0;
    // keep offering while the output is held so the input stalls
    send_nal(3, random_header(), 12);
    send_item(CMD_EOS, 8'h00);
    wait_idle();
  endtask

  task automatic test_random_stream();
    int unsigned goal;
    int          round;
    for (round = 0; round < 3; round++) begin
      wait_idle();
      write_reg(REG_MAX_TEMPORAL, 3'($urandom_range(7)));
      write_reg(REG_LAYER_LIMIT, 3'($urandom_range(7)));
      gaps_on = (round != 1);
      stalls_on = (round != 1);
      goal = items_sent + ((round == 1) ? 20 : 10);
      while (items_sent < goal) begin
        case ($urandom_range(9))
          0: repeat ($urandom_range(5, 1)) send_item(CMD_BYTE, 8'($urandom));
          1: begin
            repeat ($urandom_range(3, 2)) send_item(CMD_BYTE, 8'h00);
            send_item(CMD_BYTE, START_BYTE);
            repeat ($urandom_range(1)) send_item(CMD_BYTE, 8'($urandom));
            send_item(CMD_EOS, 8'($urandom));
          end
          default: begin
            send_nal(($urandom_range(15) == 0) ? $urandom_range(9, 5) : $urandom_range(3, 2),
                     random_header(),
                     ($urandom_range(19) == 0) ? $urandom_range(45, 30) : $urandom_range(10));
            if ($urandom_range(3) == 0) send_item(CMD_EOS, 8'($urandom));
          end
        endcase
      end
      send_item(CMD_EOS, 8'($urandom));
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Output ready: random stalls, plus one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ch.ready <= !(stalls_on && $urandom_range(99) < 14);
        if (hold_pending) hold_left = HOLD_CYCLES;
      end
    end
  end

  always @(posedge clk) begin : check_out
    nal_out_t seen;
    nal_out_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.kind, out_ch.out_byte, out_ch.keep, out_ch.layer, out_ch.temporal_plus1,
              out_ch.nal_type, out_ch.prefix_zeros, out_ch.nal_size, out_ch.zero_overflow,
              out_ch.last};
      if (nal_out_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected transaction kind %0d byte %02h", $realtime, seen.kind,
                   seen.out_byte);
      end else begin
        want = nal_out_q.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: mismatch (exp/got) kind %0d/%0d byte %02h/%02h keep %0d/%0d",
                      " layer %0d/%0d tid+1 %0d/%0d type %0d/%0d zeros %0d/%0d",
                      " size %0d/%0d ovf %0d/%0d last %0d/%0d"}, $realtime,
                     want.kind, seen.kind, want.out_byte, seen.out_byte, want.keep, seen.keep,
                     want.layer, seen.layer, want.temporal_plus1, seen.temporal_plus1,
                     want.nal_type, seen.nal_type, want.prefix_zeros, seen.prefix_zeros,
                     want.nal_size, seen.nal_size, want.zero_overflow, seen.zero_overflow,
                     want.last, seen.last);
        end
      end
    end
  end

  initial begin
    int unsigned drain_cycles;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_BYTE;
    in_ch.in_byte = 8'h00;
    model_cfg.max_temporal = 3'd6;
    model_cfg.layer_limit  = 3'd7;
    model_phase  = PH_HUNT;
    held_zeros   = 0;
    hdr_byte0    = '0;
    cur_nal_type = '0;
    cur_layer    = '0;
    cur_tid      = '0;
    cur_prefix   = '0;
    payload_len  = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_long_zero_runs();
    test_config_sweep();
    test_backpressure();
    test_random_stream();

    in_ch.valid <= 1'b0;
    drain_cycles = 0;
    while (nal_out_q.size() != 0 && drain_cycles < 50000) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    mismatches += nal_out_q.size();
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
